FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file pca_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/pca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    // Pool geometry
    localparam int POOL_BYTES   = 8192;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_CHUNKS   = 256;

    // Field and internal widths
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 13;
    localparam int STAT_W = 3;
    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int CALC_W = SIZE_W + 1;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BIG     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ROOM    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd5;

    // One chunk table entry
    typedef struct packed {
        logic             is_free;
        logic [OFF_W-1:0] bytes;
        logic [OFF_W-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request payload
    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_bytes;
        logic [OFF_W-1:0]  payload_offset;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [OFF_W-1:0]  result_offset;
        logic [STAT_W-1:0] status;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/pca_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface pca_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [pca_pkg::SIZE_W-1:0] request_bytes;
    logic [pca_pkg::OFF_W-1:0]  payload_offset;

    modport source (output valid, kind, request_bytes, payload_offset, input ready);
    modport sink   (input valid, kind, request_bytes, payload_offset, output ready);
endinterface

// Response channel
interface pca_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [pca_pkg::OFF_W-1:0]  result_offset;
    logic [pca_pkg::STAT_W-1:0] status;

    modport source (output valid, result_offset, status, input ready);
    modport sink   (input valid, result_offset, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/pool_chunk_allocator.sv
// First-free chunk allocator over a pool of pca_pkg::POOL_BYTES bytes. Each
// request on i_req (kind 0 allocate request_bytes, kind 1 free the chunk whose
// payload starts at payload_offset) gives exactly one response on o_rsp with
// the granted payload offset and a status code. The chunk table sits in one
// single-port-read RAM and is scanned one entry per cycle. A request that scans
// reads entries from index 0 up to the first free chunk (allocate), the owning
// chunk (free), or the last chunk when nothing matches; requests decided
// without a scan (zero size, too large, null free, free of an empty table,
// first allocate) go straight to the response. One request is worked at a
// time; a finished response waits in the output register while the next
// request is taken. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module pool_chunk_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pca_req_if.sink    i_req,
    pca_rsp_if.source  o_rsp
);

    pca_pkg::t_req req;
    pca_pkg::t_res done;
    logic          done_valid;
    logic          done_ready;
    logic          req_ready;
    logic          r_out_valid;
    pca_pkg::t_res r_out;

    assign req.kind           = i_req.kind;
    assign req.request_bytes  = i_req.request_bytes;
    assign req.payload_offset = i_req.payload_offset;
    assign i_req.ready        = req_ready;

    pca_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (req_ready),
        .i_req        (req),
        .o_done_valid (done_valid),
        .i_done_ready (done_ready),
        .o_done       (done)
    );

    // Output register: load when empty or being drained
    assign done_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_ready) begin
            r_out_valid <= done_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ready && done_valid) begin
            r_out <= done;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_offset = r_out.result_offset;
    assign o_rsp.status        = r_out.status;

endmodule

`default_nettype wire

FILE: hdl/pca_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/pca_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pca_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire pca_pkg::t_req i_req,
    output logic               o_done_valid,
    input  wire logic          i_done_ready,
    output pca_pkg::t_res      o_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [pca_pkg::CALC_W-1:0] HDR  =
        pca_pkg::CALC_W'(pca_pkg::HEADER_BYTES);
    localparam logic [pca_pkg::CALC_W-1:0] POOL =
        pca_pkg::CALC_W'(pca_pkg::POOL_BYTES);

    logic [1:0]                  r_state, n_state;
    logic                        r_kind, n_kind;
    logic [pca_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [pca_pkg::OFF_W-1:0]   r_off, n_off;
    logic [pca_pkg::CNT_W-1:0]   r_count, n_count;
    logic [pca_pkg::CNT_W-1:0]   r_addr, n_addr;
    logic                        r_pend, n_pend;
    logic [pca_pkg::IDX_W-1:0]   r_pend_idx, n_pend_idx;
    pca_pkg::t_res               r_res, n_res;

    // Memory port
    logic                        ram_we, ram_re;
    logic [pca_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
    pca_pkg::t_entry             ram_wdata, rd_e;
    logic [pca_pkg::ENTRY_W-1:0] ram_rdata;

    // Arithmetic on the entry under test
    logic [pca_pkg::CALC_W-1:0]  need_in, need, space, chunk_end, remaining;
    logic [pca_pkg::CNT_W-1:0]   cnt_m1;
    logic                        last, off_hit;

    pca_ram #(
        .WIDTH (pca_pkg::ENTRY_W),
        .DEPTH (pca_pkg::MAX_CHUNKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_e      = pca_pkg::t_entry'(ram_rdata);
    assign need_in   = HDR + pca_pkg::CALC_W'(i_req.request_bytes);
    assign need      = HDR + pca_pkg::CALC_W'(r_size);
    assign space     = HDR + pca_pkg::CALC_W'(rd_e.bytes);
    assign chunk_end = pca_pkg::CALC_W'(rd_e.start) + space;
    assign remaining = (chunk_end <= POOL) ? (POOL - chunk_end) : '0;
    assign off_hit   = (pca_pkg::CALC_W'(rd_e.start) + HDR) == pca_pkg::CALC_W'(r_off);
    assign cnt_m1    = r_count - pca_pkg::CNT_W'(1);
    assign last      = {1'b0, r_pend_idx} == cnt_m1;

    // Sequential table scan, one read issued per cycle
    assign ram_re    = (r_state == S_SCAN) && (r_addr < r_count);
    assign ram_raddr = r_addr[pca_pkg::IDX_W-1:0];

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_done_valid = (r_state == S_FIN);
    assign o_done       = r_res;

    // Request decode, scan decisions, write back
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_size     = r_size;
        n_off      = r_off;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_req.kind;
                    n_size  = i_req.request_bytes;
                    n_off   = i_req.payload_offset;
                    n_addr  = '0;
                    n_state = S_FIN;
                    n_res   = '0;
                    if (i_req.kind == pca_pkg::KIND_ALLOC) begin
                        if (i_req.request_bytes == '0) begin
                            n_res.status = pca_pkg::ST_ZERO;
                        end else if (need_in > POOL) begin
                            n_res.status = pca_pkg::ST_BIG;
                        end else if (r_count == '0) begin
                            // first grant claims the pool at offset 0
                            ram_we                = 1'b1;
                            ram_waddr             = '0;
                            ram_wdata.is_free     = 1'b0;
                            ram_wdata.start       = '0;
                            ram_wdata.bytes       = i_req.request_bytes[pca_pkg::OFF_W-1:0];
                            n_count               = pca_pkg::CNT_W'(1);
                            n_res.result_offset   = pca_pkg::OFF_W'(pca_pkg::HEADER_BYTES);
                            n_res.status          = pca_pkg::ST_OK;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_req.payload_offset == '0) begin
                            n_res.status = pca_pkg::ST_ZERO;
                        end else if (r_count == '0) begin
                            n_res.status = pca_pkg::ST_UNKNOWN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (ram_re) begin
                    n_addr     = r_addr + pca_pkg::CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = ram_raddr;
                end
                if (r_pend) begin
                    if (r_kind == pca_pkg::KIND_ALLOC) begin
                        if (rd_e.is_free) begin
                            // reuse first free chunk if it is big enough
                            n_state = S_FIN;
                            n_res   = '0;
                            if (need <= space) begin
                                ram_we              = 1'b1;
                                ram_waddr           = r_pend_idx;
                                ram_wdata.is_free   = 1'b0;
                                ram_wdata.start     = rd_e.start;
                                ram_wdata.bytes     = r_size[pca_pkg::OFF_W-1:0];
                                n_res.result_offset = rd_e.start +
                                    pca_pkg::OFF_W'(pca_pkg::HEADER_BYTES);
                                n_res.status        = pca_pkg::ST_OK;
                            end else begin
                                n_res.status = pca_pkg::ST_ROOM;
                            end
                        end else if (last) begin
                            // no free chunk: append after the last one if room and a table slot remain
                            n_state = S_FIN;
                            n_res   = '0;
                            if (remaining >= need) begin
                                if (r_count >= pca_pkg::CNT_W'(pca_pkg::MAX_CHUNKS)) begin
                                    n_res.status = pca_pkg::ST_FULL;
                                end else begin
                                    ram_we              = 1'b1;
                                    ram_waddr           = r_count[pca_pkg::IDX_W-1:0];
                                    ram_wdata.is_free   = 1'b0;
                                    ram_wdata.start     = chunk_end[pca_pkg::OFF_W-1:0];
                                    ram_wdata.bytes     = r_size[pca_pkg::OFF_W-1:0];
                                    n_count             = r_count + pca_pkg::CNT_W'(1);
                                    n_res.result_offset = chunk_end[pca_pkg::OFF_W-1:0] +
                                        pca_pkg::OFF_W'(pca_pkg::HEADER_BYTES);
                                    n_res.status        = pca_pkg::ST_OK;
                                end
                            end else begin
                                n_res.status = pca_pkg::ST_ROOM;
                            end
                        end
                    end else begin
                        if (off_hit) begin
                            // mark owner free, keep its geometry
                            ram_we            = 1'b1;
                            ram_waddr         = r_pend_idx;
                            ram_wdata.is_free = 1'b1;
                            ram_wdata.start   = rd_e.start;
                            ram_wdata.bytes   = rd_e.bytes;
                            n_state           = S_FIN;
                            n_res             = '0;
                            n_res.status      = pca_pkg::ST_OK;
                        end else if (last) begin
                            n_state      = S_FIN;
                            n_res        = '0;
                            n_res.status = pca_pkg::ST_UNKNOWN;
                        end
                    end
                end
            end

            S_FIN: begin
                if (i_done_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
        end
    end

    // Request payload and result
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_size     <= n_size;
        r_off      <= n_off;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
    end

endmodule

`default_nettype wire

FILE: hdl/pca_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pca_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic [pca_pkg::OFF_W-1:0]  i_rsp_offset,
    input wire logic [pca_pkg::STAT_W-1:0] i_rsp_status
);

    logic                                     rsp_granted;
    logic                                     rsp_ok;
    logic                                     past_hdr;
    logic                                     rsp_stall;
    logic [pca_pkg::OFF_W+pca_pkg::STAT_W-1:0] rsp_bits;

    // Response terms
    assign rsp_granted = i_rsp_valid && (i_rsp_offset != '0);
    assign rsp_ok      = (i_rsp_status == pca_pkg::ST_OK);
    assign past_hdr    = {1'b0, i_rsp_offset} >= (pca_pkg::OFF_W + 1)'(pca_pkg::HEADER_BYTES);
    assign rsp_stall   = i_rsp_valid && !i_rsp_ready;
    assign rsp_bits    = {i_rsp_offset, i_rsp_status};

    // One request at a time: ready drops after an accept
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // Only a good allocate carries an offset
    `ASSERT_IMPLY(a_offset_only_ok, i_clk, i_rst_n, rsp_granted, rsp_ok)

    // A granted payload lies past its header
    `ASSERT_IMPLY(a_offset_past_hdr, i_clk, i_rst_n, rsp_granted, past_hdr)

    // Stalled response holds
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(rsp_bits))

endmodule

bind pool_chunk_allocator pca_chk u_pca_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_offset (o_rsp.result_offset),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
